### sv/lrob_pkg.sv
// ----------------------------------------------------------------------------
// lrob_pkg
// Shared types, widths and codes for the octant line rasteriser.
// ----------------------------------------------------------------------------
package lrob_pkg;

  // coordinate and colour widths
  localparam int COORD_BITS = 16;
  localparam int COLOR_W    = 32;
  // first-octant point width (room for negating the most negative input)
  localparam int PT_W       = COORD_BITS + 1;
  // error term and doubled slope width
  localparam int ERR_W      = COORD_BITS + 3;

  // stream packing, filled up to whole bytes
  localparam int IN_DATA_W  = ((4 * COORD_BITS + COLOR_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + COLOR_W + 7) / 8) * 8;

  // queue depth between front and back
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  // item kinds carried in tuser
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // octant codes
  localparam logic [2:0] OCT_ONE   = 3'd0;
  localparam logic [2:0] OCT_TWO   = 3'd1;
  localparam logic [2:0] OCT_THREE = 3'd2;
  localparam logic [2:0] OCT_FOUR  = 3'd3;
  localparam logic [2:0] OCT_FIVE  = 3'd4;
  localparam logic [2:0] OCT_SIX   = 3'd5;
  localparam logic [2:0] OCT_SEVEN = 3'd6;
  localparam logic [2:0] OCT_EIGHT = 3'd7;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PT_W-1:0]       pt_t;
  typedef logic signed [ERR_W-1:0]      err_t;
  typedef logic [COLOR_W-1:0]           color_t;

  // classified item as it travels from front to back
  typedef struct packed {
    logic       action;
    logic [2:0] octant;
    pt_t        x1;
    pt_t        y1;
    pt_t        x2;
    pt_t        y2;
    color_t     color;
  } lrob_entry_t;

  // queue status seen by the back end
  typedef struct packed {
    logic        valid;
    lrob_entry_t head;
  } lrob_qhead_t;

endpackage

### sv/lrob_front.sv
// ----------------------------------------------------------------------------
// lrob_front
// Accepts input transactions, classifies start items into an octant and
// mirrors both endpoints into the first octant before queueing them.
// ----------------------------------------------------------------------------
module lrob_front import lrob_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  coord_t      in_start_x,
  input  coord_t      in_start_y,
  input  coord_t      in_end_x,
  input  coord_t      in_end_y,
  input  color_t      in_color,
  input  logic        q_full,
  output logic        q_push,
  output lrob_entry_t q_entry
);

  pt_t        sx, sy, ex, ey;
  pt_t        dx, dy, ndx, ndy;
  logic [2:0] oct;

  // mirror a point into the first octant
  function automatic void to_first(input logic [2:0] oc, input pt_t a, input pt_t b,
                                   output pt_t x, output pt_t y);
    unique case (oc)
      OCT_ONE:   begin x = a;  y = b;  end
      OCT_TWO:   begin x = b;  y = a;  end
      OCT_THREE: begin x = b;  y = -a; end
      OCT_FOUR:  begin x = -a; y = b;  end
      OCT_FIVE:  begin x = -a; y = -b; end
      OCT_SIX:   begin x = -b; y = -a; end
      OCT_SEVEN: begin x = -b; y = a;  end
      default:   begin x = a;  y = -b; end
    endcase
  endfunction

  // sign extend endpoints and take the deltas
  always_comb begin
    sx  = pt_t'({in_start_x[COORD_BITS-1], in_start_x});
    sy  = pt_t'({in_start_y[COORD_BITS-1], in_start_y});
    ex  = pt_t'({in_end_x[COORD_BITS-1], in_end_x});
    ey  = pt_t'({in_end_y[COORD_BITS-1], in_end_y});
    dx  = ex - sx;
    dy  = ey - sy;
    ndx = -dx;
    ndy = -dy;
  end

  // octant choice
  always_comb begin
    if (dx > 0) begin
      if (dy > 0) oct = (dx >= dy) ? OCT_ONE : OCT_TWO;
      else        oct = (dx >= ndy) ? OCT_EIGHT : OCT_SEVEN;
    end else begin
      if (dy > 0) oct = (ndx >= dy) ? OCT_FOUR : OCT_THREE;
      else        oct = (dx <= dy) ? OCT_FIVE : OCT_SIX;
    end
  end

  // build the queue entry
  always_comb begin
    q_entry        = '0;
    q_entry.action = in_action;
    q_entry.octant = oct;
    q_entry.color  = in_color;
    to_first(oct, sx, sy, q_entry.x1, q_entry.y1);
    to_first(oct, ex, ey, q_entry.x2, q_entry.y2);
  end

  // handshake
  assign in_ready = rst_n & ~q_full;
  assign q_push   = in_valid & in_ready;

  // a start entry always lands in the first octant
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && in_action == ACT_START) |->
      (q_entry.x2 >= q_entry.x1) && (q_entry.y2 >= q_entry.y1) &&
      ((q_entry.y2 - q_entry.y1) <= (q_entry.x2 - q_entry.x1)))
    else $error("start entry not mirrored into first octant");

  // no push into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("push while queue full");

  // equal endpoints fall in octant five
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && dx == 0 && dy == 0) |-> q_entry.octant == OCT_FIVE)
    else $error("degenerate line misclassified");

endmodule

### sv/lrob_queue.sv
// ----------------------------------------------------------------------------
// lrob_queue
// Short first-in first-out queue decoupling the front and back ends.
// ----------------------------------------------------------------------------
module lrob_queue import lrob_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  lrob_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output lrob_qhead_t head
);

  lrob_entry_t        slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  // status
  assign full       = (count_r == Q_CNT_W'(Q_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.head  = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // fill count never exceeds depth
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue overfilled");

  // nothing taken from an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
    else $error("pop from empty queue");

  // lone push grows the count by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

### sv/lrob_back.sv
// ----------------------------------------------------------------------------
// lrob_back
// Walks the first-octant line one pixel per step item, maps each pixel back
// to its real octant and holds it in an output register.
// ----------------------------------------------------------------------------
module lrob_back import lrob_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrob_qhead_t           head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_last
);

  logic                  busy_r, busy_nxt;
  logic [2:0]            oct_r;
  pt_t                   walk_x_r, walk_y_r, stop_x_r;
  err_t                  err_r, rise_r, rise_run_r;
  color_t                color_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  logic                  out_free, is_start, emit, last;
  err_t                  run_w, rise_w, e_add, e_sub;
  pt_t                   px, py;
  logic [OUT_DATA_W-1:0] pix_data;

  // dispatch
  assign out_free = ~out_valid_r | out_ready;
  assign is_start = (head.head.action == ACT_START);
  assign pop      = head.valid & (is_start | ~busy_r | out_free);
  assign emit     = pop & ~is_start & busy_r;
  assign last     = (walk_x_r >= stop_x_r);

  // slopes of a new line and the two candidate error terms
  always_comb begin
    run_w  = err_t'({{(ERR_W-PT_W){head.head.x2[PT_W-1]}}, head.head.x2})
           - err_t'({{(ERR_W-PT_W){head.head.x1[PT_W-1]}}, head.head.x1});
    rise_w = err_t'({{(ERR_W-PT_W){head.head.y2[PT_W-1]}}, head.head.y2})
           - err_t'({{(ERR_W-PT_W){head.head.y1[PT_W-1]}}, head.head.y1});
    e_add  = err_r + rise_r;
    e_sub  = err_r + rise_run_r;
  end

  // map the current pixel back to its octant
  always_comb begin
    unique case (oct_r)
      OCT_ONE:   begin px = walk_x_r;  py = walk_y_r;  end
      OCT_TWO:   begin px = walk_y_r;  py = walk_x_r;  end
      OCT_THREE: begin px = -walk_y_r; py = walk_x_r;  end
      OCT_FOUR:  begin px = -walk_x_r; py = walk_y_r;  end
      OCT_FIVE:  begin px = -walk_x_r; py = -walk_y_r; end
      OCT_SIX:   begin px = -walk_y_r; py = -walk_x_r; end
      OCT_SEVEN: begin px = walk_y_r;  py = -walk_x_r; end
      default:   begin px = walk_x_r;  py = -walk_y_r; end
    endcase
    pix_data = '0;
    pix_data[COORD_BITS-1:0]                      = px[COORD_BITS-1:0];
    pix_data[2*COORD_BITS-1:COORD_BITS]           = py[COORD_BITS-1:0];
    pix_data[2*COORD_BITS+COLOR_W-1:2*COORD_BITS] = color_r;
  end

  // busy flag
  always_comb begin
    busy_nxt = busy_r;
    if (pop && is_start) busy_nxt = 1'b1;
    else if (emit && last) busy_nxt = 1'b0;
  end

  // output register valid
  always_comb begin
    if (emit)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // line state: load on start, advance on step
  always_ff @(posedge clk) begin
    if (pop && is_start) begin
      oct_r      <= head.head.octant;
      walk_x_r   <= head.head.x1;
      walk_y_r   <= head.head.y1;
      stop_x_r   <= head.head.x2;
      color_r    <= head.head.color;
      err_r      <= -run_w;
      rise_r     <= rise_w + rise_w;
      rise_run_r <= (rise_w - run_w) + (rise_w - run_w);
    end else if (emit && !last) begin
      walk_x_r <= walk_x_r + pt_t'(1);
      if (e_add > 0) begin
        walk_y_r <= walk_y_r + pt_t'(1);
        err_r    <= e_sub;
      end else begin
        err_r    <= e_add;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= pix_data;
      out_last_r <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  // walker never passes the end point
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> walk_x_r <= stop_x_r)
    else $error("walk passed the end of the line");

  // error term stays non-positive between steps
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> err_r <= 0)
    else $error("error term out of range");

  // last pixel ends the line
  assert property (@(posedge clk) disable iff (!rst_n) (emit && last) |=> !busy_r)
    else $error("line still busy after last pixel");

endmodule

### sv/line_raster_octant_bresenham.sv
// ----------------------------------------------------------------------------
// line_raster_octant_bresenham
// Octant-normalised line rasteriser: start items set up a line, step items
// each produce one pixel.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                        tuser / tlast
//  in_      in   start_x, start_y, end_x, end_y, line_color  tuser: action
//  out_     out  pixel_x, pixel_y, pixel_color               tlast: last_pixel
//
//  One transaction per clock in each direction, sustained while out_tready is
//  high; a step's pixel is registered after it leaves the two-entry queue.
//  The line walk (two adds, a compare on the error term) sets the pixel rate.
//  Synchronous active-low reset clears queue, busy flag and output valid.
//  A stalled output holds the pixel; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module line_raster_octant_bresenham import lrob_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_x, start_y, end_x, end_y, line_color
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic        q_push, q_full, q_pop;
  lrob_entry_t q_entry;
  lrob_qhead_t q_head;

  // front end: classify and mirror
  lrob_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser),
    .in_start_x (coord_t'(in_tdata[COORD_BITS-1:0])),
    .in_start_y (coord_t'(in_tdata[2*COORD_BITS-1:COORD_BITS])),
    .in_end_x   (coord_t'(in_tdata[3*COORD_BITS-1:2*COORD_BITS])),
    .in_end_y   (coord_t'(in_tdata[4*COORD_BITS-1:3*COORD_BITS])),
    .in_color   (in_tdata[4*COORD_BITS+COLOR_W-1:4*COORD_BITS]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // decoupling queue
  lrob_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  // back end: line walk and output register
  lrob_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

### dv/line_raster_octant_bresenham_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_raster_octant_bresenham_test
// Self-checking bench for the octant line rasteriser. Start and step items are
// streamed in bursts; a behavioural line walker predicts every pixel and the
// result stream is compared against it under a varying back-pressure pattern.
// ----------------------------------------------------------------------------
module line_raster_octant_bresenham_test;
  import lrob_pkg::*;

  localparam int COORD_MIN    = -(2 ** (COORD_BITS - 1));
  localparam int COORD_MAX    = 2 ** (COORD_BITS - 1) - 1;
  localparam int ITEM_TARGET  = 1250;
  localparam int QUIET_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 16;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic   action;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    color_t color;
    bit     hold_for_drain;
  } line_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  typedef enum {READY_ALWAYS, READY_MOSTLY, READY_SELDOM, READY_PERIODIC} ready_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // start_x, start_y, end_x, end_y, line_color
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // action
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // pixel_x, pixel_y, pixel_color
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  line_item_t lines_to_send[$];
  pixel_t     pixels_due[$];
  int         fault_count = 0;
  int         quiet_cycles = 0;
  int         gap_left = 0;
  int         burst_left = 0;
  int         items_planned = 0;
  int         plan_pixels_left = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int         ready_hold = 0;
  int         ready_tick = 0;

  // line walker state, first-octant coordinates
  logic       walk_busy = 1'b0;
  logic [2:0] walk_octant = OCT_ONE;
  pt_t        walk_x = '0;
  pt_t        walk_y = '0;
  pt_t        walk_stop_x = '0;
  err_t       walk_error = '0;
  err_t       walk_run2 = '0;
  err_t       walk_rise2 = '0;
  color_t     walk_color = '0;

  line_raster_octant_bresenham dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // line walker
  // ---------------------------------------------------------------------------

  function automatic logic [2:0] octant_of(input int dx, input int dy);
    if (dx > 0) begin
      if (dy > 0) return (dx >= dy) ? OCT_ONE : OCT_TWO;
      return (dx >= -dy) ? OCT_EIGHT : OCT_SEVEN;
    end
    if (dy > 0) return (-dx >= dy) ? OCT_FOUR : OCT_THREE;
    return (dx <= dy) ? OCT_FIVE : OCT_SIX;
  endfunction

  function automatic void fold_to_first(input logic [2:0] oct, input int a, input int b,
                                        output int x, output int y);
    case (oct)
      OCT_ONE:   begin x = a;  y = b;  end
      OCT_TWO:   begin x = b;  y = a;  end
      OCT_THREE: begin x = b;  y = -a; end
      OCT_FOUR:  begin x = -a; y = b;  end
      OCT_FIVE:  begin x = -a; y = -b; end
      OCT_SIX:   begin x = -b; y = -a; end
      OCT_SEVEN: begin x = -b; y = a;  end
      default:   begin x = a;  y = -b; end
    endcase
  endfunction

  function automatic void unfold_from_first(input logic [2:0] oct, input int a, input int b,
                                            output int x, output int y);
    case (oct)
      OCT_ONE:   begin x = a;  y = b;  end
      OCT_TWO:   begin x = b;  y = a;  end
      OCT_THREE: begin x = -b; y = a;  end
      OCT_FOUR:  begin x = -a; y = b;  end
      OCT_FIVE:  begin x = -a; y = -b; end
      OCT_SIX:   begin x = -b; y = -a; end
      OCT_SEVEN: begin x = b;  y = -a; end
      default:   begin x = a;  y = -b; end
    endcase
  endfunction

  // advance the walker by one accepted item, queueing any pixel it plots
  function automatic void walk_line_item(input line_item_t it);
    int     x1, y1, x2, y2, px, py;
    pixel_t pix;
    if (it.action == ACT_START) begin
      walk_octant = octant_of(int'(it.ex) - int'(it.sx), int'(it.ey) - int'(it.sy));
      fold_to_first(walk_octant, int'(it.sx), int'(it.sy), x1, y1);
      fold_to_first(walk_octant, int'(it.ex), int'(it.ey), x2, y2);
      walk_run2   = err_t'(2 * (x2 - x1));
      walk_rise2  = err_t'(2 * (y2 - y1));
      walk_error  = err_t'(x1 - x2);
      walk_x      = pt_t'(x1);
      walk_y      = pt_t'(y1);
      walk_stop_x = pt_t'(x2);
      walk_color  = it.color;
      walk_busy   = 1'b1;
    end else if (walk_busy) begin
      unfold_from_first(walk_octant, int'(walk_x), int'(walk_y), px, py);
      pix.x     = coord_t'(px);
      pix.y     = coord_t'(py);
      pix.color = walk_color;
      pix.last  = (walk_x >= walk_stop_x);
      pixels_due.insert(pixels_due.size(), pix);
      if (pix.last) begin
        walk_busy = 1'b0;
      end else begin
        walk_x     = walk_x + pt_t'(1);
        walk_error = walk_error + walk_rise2;
        // ties keep the minor coordinate
        if (walk_error > 0) begin
          walk_y     = walk_y + pt_t'(1);
          walk_error = walk_error - walk_run2;
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic line_item_t step_item();
    line_item_t it;
    it.action         = ACT_STEP;
    it.sx             = coord_t'($urandom);
    it.sy             = coord_t'($urandom);
    it.ex             = coord_t'($urandom);
    it.ey             = coord_t'($urandom);
    it.color          = $urandom;
    it.hold_for_drain = 1'b0;
    return it;
  endfunction

  function automatic int pixel_count(input int sx, input int sy, input int ex, input int ey);
    int ax, ay;
    ax = (ex > sx) ? ex - sx : sx - ex;
    ay = (ey > sy) ? ey - sy : sy - ey;
    return ((ax > ay) ? ax : ay) + 1;
  endfunction

  // start item followed by a run of step items
  function automatic void plan_line(input int sx, input int sy, input int ex, input int ey,
                                    input color_t c, input int steps, input bit drain);
    line_item_t it;
    it.action         = ACT_START;
    it.sx             = coord_t'(sx);
    it.sy             = coord_t'(sy);
    it.ex             = coord_t'(ex);
    it.ey             = coord_t'(ey);
    it.color          = c;
    it.hold_for_drain = drain;
    lines_to_send.insert(lines_to_send.size(), it);
    items_planned++;
    plan_pixels_left = pixel_count(sx, sy, ex, ey);
    for (int i = 0; i < steps; i++) begin
      lines_to_send.insert(lines_to_send.size(), step_item());
      // steps past the end are ignored and do not count
      if (plan_pixels_left > 0) begin
        items_planned++;
        plan_pixels_left--;
      end
    end
  endfunction

  function automatic int random_coord();
    case ($urandom_range(0, 5))
      0:       return COORD_MIN + $urandom_range(0, 8);
      1:       return COORD_MAX - $urandom_range(0, 8);
      default: return int'(coord_t'($urandom));
    endcase
  endfunction

  // endpoint a short distance away, turned back if it would leave the range
  function automatic int near_coord(input int s, input int span);
    int d, e;
    d = $urandom_range(0, 2 * span) - span;
    e = s + d;
    if (e > COORD_MAX || e < COORD_MIN) e = s - d;
    return e;
  endfunction

  function automatic logic [IN_DATA_W-1:0] item_to_tdata(input line_item_t it);
    return IN_DATA_W'({it.color, it.ey, it.ex, it.sy, it.sx});
  endfunction

  function automatic string describe(input pixel_t p);
    return $sformatf("x=%0d y=%0d colour=%08h last=%0b", p.x, p.y, p.color, p.last);
  endfunction

  function automatic void note_fault(input string msg);
    if (fault_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    fault_count++;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int sx, sy, ex, ey, pick, span, steps;
    bit first_random;

    // directed: idle step, single-pixel line, tie on the error term
    lines_to_send.insert(lines_to_send.size(), step_item());
    plan_line(7, -3, 7, -3, 32'hFFFF_FFFF, 2, 1'b0);
    plan_line(0, 0, 2, 1, 32'h0000_0000, 3, 1'b0);
    // one short line per octant from the corners, each cut short by the next start
    plan_line(COORD_MIN, COORD_MIN, COORD_MIN + 3, COORD_MIN + 1, 32'h1111_1111, 1, 1'b0);
    plan_line(COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MIN + 3, 32'h2222_2222, 1, 1'b0);
    plan_line(COORD_MAX, COORD_MIN, COORD_MAX - 1, COORD_MIN + 3, 32'h3333_3333, 1, 1'b0);
    plan_line(COORD_MAX, COORD_MIN, COORD_MAX - 3, COORD_MIN + 1, 32'h4444_4444, 1, 1'b0);
    plan_line(COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX - 1, 32'h5555_5555, 1, 1'b0);
    plan_line(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX - 3, 32'h6666_6666, 1, 1'b0);
    plan_line(COORD_MIN, COORD_MAX, COORD_MIN + 1, COORD_MAX - 3, 32'h7777_7777, 1, 1'b0);
    plan_line(COORD_MIN, COORD_MAX, COORD_MIN + 3, COORD_MAX - 1, 32'h8888_8888, 1, 1'b0);
    // corner to corner, widest run
    plan_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 32'hA5A5_5A5A, 2, 1'b0);

    // random lines, mostly walked to the end
    first_random = 1'b1;
    while (items_planned < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      sx   = random_coord();
      sy   = random_coord();
      if (pick < 5) begin
        ex    = random_coord();
        ey    = random_coord();
        steps = $urandom_range(0, 6);
      end else begin
        span  = (pick < 12) ? 300 : 12;
        ex    = near_coord(sx, span);
        ey    = near_coord(sy, span);
        steps = pixel_count(sx, sy, ex, ey);
        if (pick < 20) steps = $urandom_range(0, steps);
        else if (pick < 28) steps += $urandom_range(1, 3);
      end
      plan_line(sx, sy, ex, ey, $urandom, steps,
                first_random || ($urandom_range(0, 39) == 0));
      first_random = 1'b0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (lines_to_send.size() != 0 || in_tvalid) @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // input driver: bursts with random gaps, optional drain before an item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic send;
    send = 1'b0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        walk_line_item(lines_to_send.pop_front());
      end
      if (lines_to_send.size() != 0) begin
        if (lines_to_send[0].hold_for_drain && pixels_due.size() != 0) begin
          send = 1'b0;
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          send = 1'b1;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
          end
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_tvalid <= send;
      if (send) begin
        in_tdata <= item_to_tdata(lines_to_send[0]);
        in_tuser <= lines_to_send[0].action;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output back-pressure, pattern changes every so often
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic ready_next;
    if (ready_hold == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_hold = $urandom_range(20, 200);
    end else begin
      ready_hold--;
    end
    case (ready_mode)
      READY_ALWAYS: ready_next = 1'b1;
      READY_MOSTLY: ready_next = ($urandom_range(0, 3) != 0);
      READY_SELDOM: ready_next = ($urandom_range(0, 3) == 0);
      default:      ready_next = ((ready_tick % 5) < 3);
    endcase
    ready_tick++;
    out_tready <= ready_next;
  end

  // ---------------------------------------------------------------------------
  // output monitor and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.x     = coord_t'(out_tdata[COORD_BITS-1:0]);
      got.y     = coord_t'(out_tdata[2*COORD_BITS-1:COORD_BITS]);
      got.color = out_tdata[2*COORD_BITS+COLOR_W-1:2*COORD_BITS];
      got.last  = out_tlast;
      if (pixels_due.size() == 0) begin
        note_fault({"pixel with none expected: ", describe(got)});
      end else begin
        want = pixels_due.pop_front();
        if (got.x !== want.x || got.y !== want.y ||
            got.color !== want.color || got.last !== want.last) begin
          note_fault({"expected ", describe(want), " got ", describe(got)});
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog on transaction-free cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
